// ===== rtl/usrm_pkg.sv =====
// Shared constants, codes and the result record of the USART register model.
package usrm_pkg;

  // Queue sizes and the widths that follow from them.
  localparam int RX_DEPTH = 16;
  localparam int TX_DEPTH = 4;
  localparam int RX_AW = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;
  localparam int TX_AW = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;
  localparam int RX_CW = $clog2(RX_DEPTH + 1);
  localparam int TX_CW = $clog2(TX_DEPTH + 1);

  // Item operation codes.
  localparam logic [2:0] OP_WRITE   = 3'd0;
  localparam logic [2:0] OP_READ    = 3'd1;
  localparam logic [2:0] OP_RXBYTE  = 3'd2;
  localparam logic [2:0] OP_RXBREAK = 3'd3;
  localparam logic [2:0] OP_DSR     = 3'd4;
  localparam logic [2:0] OP_FLUSH   = 3'd5;
  localparam logic [2:0] OP_TICK    = 3'd6;

  // Status register bit positions.
  localparam int ST_TXRDY  = 0;
  localparam int ST_RXRDY  = 1;
  localparam int ST_TXE    = 2;
  localparam int ST_PE     = 3;
  localparam int ST_OE     = 4;
  localparam int ST_FE     = 5;
  localparam int ST_SYNDET = 6;
  localparam int ST_DSR    = 7;
  localparam logic [7:0] STATUS_RESET = 8'h05;

  // Command byte bit positions.
  localparam int CMD_TXEN = 0;
  localparam int CMD_DTR  = 1;
  localparam int CMD_RXEN = 2;
  localparam int CMD_SBRK = 3;
  localparam int CMD_ER   = 4;
  localparam int CMD_RTS  = 5;
  localparam int CMD_IR   = 6;

  // Mode byte: bit 7 selects a single sync character in sync mode.
  localparam int MODE_SINGLE_SYNC = 7;

  // Mode sequencer phases.
  localparam logic [2:0] PH_CLEAR = 3'd0;
  localparam logic [2:0] PH_SYNC  = 3'd1;
  localparam logic [2:0] PH_ASYNC = 3'd2;
  localparam logic [2:0] PH_SYNC1 = 3'd3;
  localparam logic [2:0] PH_SYNC2 = 3'd4;

  // Configuration register indexes.
  localparam logic [1:0] CFG_RX_DELAY = 2'd0;
  localparam logic [1:0] CFG_TX_DELAY = 2'd1;
  localparam logic [1:0] CFG_LOOPBACK = 2'd2;
  localparam logic [15:0] DELAY_RESET = 16'd100;

  // Receive queue entry marking a break.
  localparam logic [8:0] RX_BREAK_ENTRY = 9'h100;

  // One result item.
  typedef struct packed {
    logic [7:0] read_data;
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       dtr_level;
    logic       rts_level;
    logic       break_level;
    logic       txrdy_level;
    logic       rxrdy_level;
    logic       txe_level;
    logic       syndet_level;
  } res_t;

endpackage

// ===== rtl/usrm_ram.sv =====
// Simple dual-port synchronous RAM with one write port and a registered read port.
module usrm_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/usart_register_model.sv =====
// Top level of the USART register model: sequencer, status, queues and timers.
//
// Items arrive on the input channel (in_valid, in_stall, operation, address_bit,
// value) and each item yields exactly one result on the output channel
// (out_valid, out_stall and the result fields). A transfer happens at a rising
// clock edge where valid is high and stall is low.
// Each item is processed in the cycle it is accepted and its result is
// registered in the output register, or in the skid entry while out_stall holds it.
// Throughput is one item per cycle while in_stall is low: the queue heads are
// prefetched through the registered read ports of the queue RAMs, with the read data
// forwarded when the same entry is written, so a tick can pop an entry without waiting for a RAM read.
// Results go to an output register backed by one skid entry. The input stalls
// only while that skid entry is occupied, that is when the receiver has held
// out_stall while two results were waiting.
// Configuration is written through cfg_we, cfg_index and cfg_data while idle.
// Synchronous reset restores the delays to 100 ticks, disables loopback,
// empties both queues, stops both timers and drops pending results; no
// clearing pass is needed because queue entries are read only after writing.
module usart_register_model (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  operation,
  input  logic        address_bit,
  input  logic [7:0]  value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  read_data,
  output logic        tx_valid,
  output logic [7:0]  tx_byte,
  output logic        dtr_level,
  output logic        rts_level,
  output logic        break_level,
  output logic        txrdy_level,
  output logic        rxrdy_level,
  output logic        txe_level,
  output logic        syndet_level
);

  localparam int RXAW = usrm_pkg::RX_AW;
  localparam int TXAW = usrm_pkg::TX_AW;
  localparam int RXCW = usrm_pkg::RX_CW;
  localparam int TXCW = usrm_pkg::TX_CW;

  // Configuration registers.
  logic [15:0] rx_delay;
  logic [15:0] tx_delay;
  logic        loopback;

  // Block state.
  logic [2:0]      phase, phase_next;
  logic [7:0]      status, status_next;
  logic [7:0]      rbyte, rbyte_next;
  logic            tx_en, tx_en_next;
  logic            rx_en, rx_en_next;
  logic            dtr, dtr_next;
  logic            rts, rts_next;
  logic            brk, brk_next;
  logic [RXAW-1:0] rx_head, rx_head_next;
  logic [RXCW-1:0] rx_cnt, rx_cnt_next;
  logic [TXAW-1:0] tx_head, tx_head_next;
  logic [TXCW-1:0] tx_cnt, tx_cnt_next;
  logic            rx_act, rx_act_next;
  logic            tx_act, tx_act_next;
  logic [15:0]     rx_tmr, rx_tmr_next;
  logic [15:0]     tx_tmr, tx_tmr_next;

  // Queue RAM ports and head-entry forwarding.
  logic            rx_we;
  logic [RXAW-1:0] rx_waddr;
  logic [8:0]      rx_wdata;
  logic [8:0]      rx_ram_q;
  logic            rx_fwd;
  logic [8:0]      rx_fwd_data;
  logic [8:0]      rx_head_data;
  logic            tx_we;
  logic [TXAW-1:0] tx_waddr;
  logic [7:0]      tx_wdata;
  logic [7:0]      tx_ram_q;
  logic            tx_fwd;
  logic [7:0]      tx_fwd_data;
  logic [7:0]      tx_head_data;

  // Item processing.
  logic            acc;
  logic [15:0]     rx_delay_eff;
  logic [15:0]     tx_delay_eff;
  logic            push_req;
  logic [8:0]      push_data;
  logic [RXAW:0]   rx_sum;
  logic [TXAW:0]   tx_sum;
  logic [TXAW-1:0] tx_wptr;
  logic [RXAW-1:0] rx_head_inc;
  logic [TXAW-1:0] tx_head_inc;
  logic [7:0]      rd_val;
  logic            txv;
  logic [7:0]      txb;
  usrm_pkg::res_t  res_next;

  // Output register and skid entry.
  usrm_pkg::res_t  out_res;
  usrm_pkg::res_t  skid_res;
  logic            skid_valid;

  assign acc      = in_valid && !in_stall;
  assign in_stall = skid_valid;

  // A zero delay counts as one tick.
  assign rx_delay_eff = (rx_delay == 16'd0) ? 16'd1 : rx_delay;
  assign tx_delay_eff = (tx_delay == 16'd0) ? 16'd1 : tx_delay;

  // Queue head entries, taking the forwarded write when the head was just written.
  assign rx_head_data = rx_fwd ? rx_fwd_data : rx_ram_q;
  assign tx_head_data = tx_fwd ? tx_fwd_data : tx_ram_q;

  // Head increments with wrap, and the transmit write slot.
  assign rx_head_inc = (rx_head == RXAW'(usrm_pkg::RX_DEPTH - 1)) ? '0 : rx_head + 1'b1;
  assign tx_head_inc = (tx_head == TXAW'(usrm_pkg::TX_DEPTH - 1)) ? '0 : tx_head + 1'b1;
  assign tx_sum  = {1'b0, tx_head} + (TXAW + 1)'(tx_cnt);
  assign tx_wptr = (tx_sum >= (TXAW + 1)'(usrm_pkg::TX_DEPTH))
                   ? TXAW'(tx_sum - (TXAW + 1)'(usrm_pkg::TX_DEPTH)) : TXAW'(tx_sum);

  // Next-state logic for one accepted item.
  always_comb begin
    phase_next   = phase;
    status_next  = status;
    rbyte_next   = rbyte;
    tx_en_next   = tx_en;
    rx_en_next   = rx_en;
    dtr_next     = dtr;
    rts_next     = rts;
    brk_next     = brk;
    rx_head_next = rx_head;
    rx_cnt_next  = rx_cnt;
    tx_head_next = tx_head;
    tx_cnt_next  = tx_cnt;
    rx_act_next  = rx_act;
    tx_act_next  = tx_act;
    rx_tmr_next  = rx_tmr;
    tx_tmr_next  = tx_tmr;
    rx_we        = 1'b0;
    rx_waddr     = '0;
    rx_wdata     = '0;
    rx_sum       = '0;
    tx_we        = 1'b0;
    tx_waddr     = tx_wptr;
    tx_wdata     = value;
    push_req     = 1'b0;
    push_data    = '0;
    rd_val       = '0;
    txv          = 1'b0;
    txb          = '0;

    if (acc) begin
      case (operation)
        usrm_pkg::OP_WRITE: begin
          if (address_bit) begin
            // Mode sequencer: mode byte, sync bytes, then commands.
            case (phase)
              usrm_pkg::PH_CLEAR: begin
                if (value[1:0] != 2'b00) begin
                  phase_next = usrm_pkg::PH_ASYNC;
                end else if (value[usrm_pkg::MODE_SINGLE_SYNC]) begin
                  phase_next = usrm_pkg::PH_SYNC2;
                end else begin
                  phase_next = usrm_pkg::PH_SYNC1;
                end
              end
              usrm_pkg::PH_SYNC1: phase_next = usrm_pkg::PH_SYNC2;
              usrm_pkg::PH_SYNC2: phase_next = usrm_pkg::PH_SYNC;
              default: begin
                if (value[usrm_pkg::CMD_IR]) begin
                  phase_next = usrm_pkg::PH_CLEAR;
                end else begin
                  if (value[usrm_pkg::CMD_ER]) begin
                    status_next[usrm_pkg::ST_PE] = 1'b0;
                    status_next[usrm_pkg::ST_OE] = 1'b0;
                    status_next[usrm_pkg::ST_FE] = 1'b0;
                  end
                  dtr_next   = value[usrm_pkg::CMD_DTR];
                  brk_next   = value[usrm_pkg::CMD_SBRK];
                  rts_next   = value[usrm_pkg::CMD_RTS];
                  rx_en_next = value[usrm_pkg::CMD_RXEN];
                  tx_en_next = value[usrm_pkg::CMD_TXEN];
                  if (rx_en_next && rx_cnt != '0 && !rx_act) begin
                    rx_act_next = 1'b1;
                    rx_tmr_next = rx_delay_eff;
                  end
                  if (tx_en_next && tx_cnt != '0 && !tx_act) begin
                    tx_act_next = 1'b1;
                    tx_tmr_next = tx_delay_eff;
                  end
                end
              end
            endcase
          end else if (status[usrm_pkg::ST_TXRDY] &&
                       tx_cnt < TXCW'(usrm_pkg::TX_DEPTH)) begin
            // Data write into the transmit queue.
            tx_we       = 1'b1;
            tx_cnt_next = tx_cnt + 1'b1;
            if (tx_cnt_next == TXCW'(usrm_pkg::TX_DEPTH)) begin
              status_next[usrm_pkg::ST_TXRDY] = 1'b0;
            end
            status_next[usrm_pkg::ST_TXE] = 1'b0;
            if (tx_en && !tx_act) begin
              tx_act_next = 1'b1;
              tx_tmr_next = tx_delay_eff;
            end
          end
        end
        usrm_pkg::OP_READ: begin
          if (address_bit) begin
            rd_val = status;
            if (!tx_en) begin
              rd_val[usrm_pkg::ST_TXRDY] = 1'b0;
              rd_val[usrm_pkg::ST_TXE]   = 1'b0;
            end
          end else begin
            status_next[usrm_pkg::ST_RXRDY] = 1'b0;
            rd_val = rbyte;
          end
        end
        usrm_pkg::OP_RXBYTE: begin
          push_req  = 1'b1;
          push_data = {1'b0, value};
        end
        usrm_pkg::OP_RXBREAK: begin
          if (value != 8'd0) begin
            push_req  = 1'b1;
            push_data = usrm_pkg::RX_BREAK_ENTRY;
          end
        end
        usrm_pkg::OP_DSR: status_next[usrm_pkg::ST_DSR] = (value != 8'd0);
        usrm_pkg::OP_FLUSH: begin
          rx_cnt_next  = '0;
          rx_head_next = '0;
        end
        usrm_pkg::OP_TICK: begin
          // Receive timer is serviced first.
          if (rx_act) begin
            if (rx_tmr > 16'd1) begin
              rx_tmr_next = rx_tmr - 1'b1;
            end else begin
              rx_tmr_next = '0;
              if (rx_en && !status[usrm_pkg::ST_RXRDY] && rx_cnt != '0) begin
                rx_head_next = rx_head_inc;
                rx_cnt_next  = rx_cnt - 1'b1;
                if (rx_head_data[8]) begin
                  status_next[usrm_pkg::ST_SYNDET] = 1'b1;
                end else begin
                  rbyte_next = rx_head_data[7:0];
                  status_next[usrm_pkg::ST_RXRDY] = 1'b1;
                end
              end
              if (rx_en && rx_cnt_next != '0) begin
                rx_act_next = 1'b1;
                rx_tmr_next = rx_delay_eff;
              end else begin
                rx_act_next = 1'b0;
              end
            end
          end
          // Transmit timer moves one byte to the line or into the receive queue.
          if (tx_act) begin
            if (tx_tmr > 16'd1) begin
              tx_tmr_next = tx_tmr - 1'b1;
            end else begin
              tx_tmr_next = '0;
              if (tx_en && tx_cnt != '0) begin
                tx_head_next = tx_head_inc;
                tx_cnt_next  = tx_cnt - 1'b1;
                if (loopback) begin
                  push_req  = 1'b1;
                  push_data = {1'b0, tx_head_data};
                end else begin
                  txv = 1'b1;
                  txb = tx_head_data;
                end
                status_next[usrm_pkg::ST_TXRDY] = 1'b1;
                if (tx_cnt_next == '0) begin
                  status_next[usrm_pkg::ST_TXE] = 1'b1;
                end
              end
              if (tx_en && tx_cnt_next != '0) begin
                tx_act_next = 1'b1;
                tx_tmr_next = tx_delay_eff;
              end else begin
                tx_act_next = 1'b0;
              end
            end
          end
        end
        default: ;
      endcase

      // Receive queue push; a full queue drops the entry.
      if (push_req) begin
        if (rx_cnt_next < RXCW'(usrm_pkg::RX_DEPTH)) begin
          rx_sum   = {1'b0, rx_head_next} + (RXAW + 1)'(rx_cnt_next);
          rx_we    = 1'b1;
          rx_wdata = push_data;
          rx_waddr = (rx_sum >= (RXAW + 1)'(usrm_pkg::RX_DEPTH))
                     ? RXAW'(rx_sum - (RXAW + 1)'(usrm_pkg::RX_DEPTH)) : RXAW'(rx_sum);
          rx_cnt_next = rx_cnt_next + 1'b1;
        end
        if (rx_en_next && rx_cnt_next != '0 && !rx_act_next) begin
          rx_act_next = 1'b1;
          rx_tmr_next = rx_delay_eff;
        end
      end
    end
  end

  // Result of the current item, taken from the state after it.
  always_comb begin
    res_next.read_data    = rd_val;
    res_next.tx_valid     = txv;
    res_next.tx_byte      = txb;
    res_next.dtr_level    = dtr_next;
    res_next.rts_level    = rts_next;
    res_next.break_level  = brk_next;
    res_next.txrdy_level  = status_next[usrm_pkg::ST_TXRDY];
    res_next.rxrdy_level  = status_next[usrm_pkg::ST_RXRDY];
    res_next.txe_level    = status_next[usrm_pkg::ST_TXE];
    res_next.syndet_level = status_next[usrm_pkg::ST_SYNDET];
  end

  // Queue memories; the read address always follows the next head.
  usrm_ram #(.DEPTH(usrm_pkg::RX_DEPTH), .WIDTH(9)) u_rx_ram (
    .clk   (clk),
    .we    (rx_we),
    .waddr (rx_waddr),
    .wdata (rx_wdata),
    .raddr (rx_head_next),
    .rdata (rx_ram_q)
  );

  usrm_ram #(.DEPTH(usrm_pkg::TX_DEPTH), .WIDTH(8)) u_tx_ram (
    .clk   (clk),
    .we    (tx_we),
    .waddr (tx_waddr),
    .wdata (tx_wdata),
    .raddr (tx_head_next),
    .rdata (tx_ram_q)
  );

  // Forwarding data for a write that lands on the entry being read.
  always_ff @(posedge clk) begin
    rx_fwd_data <= rx_wdata;
    tx_fwd_data <= tx_wdata;
  end

  // Control state, configuration and output handshake.
  always_ff @(posedge clk) begin
    if (rst) begin
      rx_delay   <= usrm_pkg::DELAY_RESET;
      tx_delay   <= usrm_pkg::DELAY_RESET;
      loopback   <= 1'b0;
      phase      <= usrm_pkg::PH_CLEAR;
      status     <= usrm_pkg::STATUS_RESET;
      rbyte      <= '0;
      tx_en      <= 1'b0;
      rx_en      <= 1'b0;
      dtr        <= 1'b0;
      rts        <= 1'b0;
      brk        <= 1'b0;
      rx_head    <= '0;
      rx_cnt     <= '0;
      tx_head    <= '0;
      tx_cnt     <= '0;
      rx_act     <= 1'b0;
      tx_act     <= 1'b0;
      rx_tmr     <= '0;
      tx_tmr     <= '0;
      rx_fwd     <= 1'b0;
      tx_fwd     <= 1'b0;
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          usrm_pkg::CFG_RX_DELAY: rx_delay <= cfg_data;
          usrm_pkg::CFG_TX_DELAY: tx_delay <= cfg_data;
          usrm_pkg::CFG_LOOPBACK: loopback <= cfg_data[0];
          default: ;
        endcase
      end
      phase   <= phase_next;
      status  <= status_next;
      rbyte   <= rbyte_next;
      tx_en   <= tx_en_next;
      rx_en   <= rx_en_next;
      dtr     <= dtr_next;
      rts     <= rts_next;
      brk     <= brk_next;
      rx_head <= rx_head_next;
      rx_cnt  <= rx_cnt_next;
      tx_head <= tx_head_next;
      tx_cnt  <= tx_cnt_next;
      rx_act  <= rx_act_next;
      tx_act  <= tx_act_next;
      rx_tmr  <= rx_tmr_next;
      tx_tmr  <= tx_tmr_next;
      rx_fwd  <= rx_we && (rx_waddr == rx_head_next);
      tx_fwd  <= tx_we && (tx_waddr == tx_head_next);

      // Output register with one skid entry behind it.
      if (skid_valid) begin
        if (!out_stall) begin
          skid_valid <= 1'b0;
        end
      end else if (acc) begin
        if (out_valid && out_stall) begin
          skid_valid <= 1'b1;
        end else begin
          out_valid <= 1'b1;
        end
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result payload registers.
  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (!out_stall) begin
        out_res <= skid_res;
      end
    end else if (acc) begin
      if (out_valid && out_stall) begin
        skid_res <= res_next;
      end else begin
        out_res <= res_next;
      end
    end
  end

  assign read_data    = out_res.read_data;
  assign tx_valid     = out_res.tx_valid;
  assign tx_byte      = out_res.tx_byte;
  assign dtr_level    = out_res.dtr_level;
  assign rts_level    = out_res.rts_level;
  assign break_level  = out_res.break_level;
  assign txrdy_level  = out_res.txrdy_level;
  assign rxrdy_level  = out_res.rxrdy_level;
  assign txe_level    = out_res.txe_level;
  assign syndet_level = out_res.syndet_level;

  // The skid entry is only used behind a waiting output register.
  assert property (@(posedge clk) disable iff (rst) skid_valid |-> out_valid)
    else $error("skid entry holds a result while the output register is empty");

  // The transmitter is not ready only when its queue is full.
  assert property (@(posedge clk) disable iff (rst)
    !status[usrm_pkg::ST_TXRDY] |-> (tx_cnt == TXCW'(usrm_pkg::TX_DEPTH)))
    else $error("TXRDY clear with room left in the transmit queue");

  // The transmitter reports empty only with an empty queue.
  assert property (@(posedge clk) disable iff (rst)
    status[usrm_pkg::ST_TXE] |-> (tx_cnt == '0))
    else $error("TXE set with bytes still queued");

  // A running receive timer never holds a zero count.
  assert property (@(posedge clk) disable iff (rst) rx_act |-> (rx_tmr != '0))
    else $error("receive timer active with a zero count");

endmodule

// ===== dv/tb_usart_register_model.sv =====
// Self-checking testbench for the USART register model: directed table, random phases, predictor.
module tb_usart_register_model;

  // Operation code outside the defined set; the block must leave its state alone.
  localparam logic [2:0] OP_NONE = 3'd7;
  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASES = 5;
  localparam int ITEMS_PER_PHASE = 360;

  // Delay and loopback settings of the random phases, zero and full scale among them.
  localparam logic [15:0] PHASE_RX_DELAY [PHASES] = '{16'd0, 16'd3, 16'hFFFF, 16'd1, 16'd2};
  localparam logic [15:0] PHASE_TX_DELAY [PHASES] = '{16'd0, 16'd2, 16'hFFFF, 16'd4, 16'd1};
  localparam logic        PHASE_LOOP     [PHASES] = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0};

  // Result of an idle block straight after reset, and after the first full command.
  localparam usrm_pkg::res_t RES_IDLE = '{read_data: 8'h00, tx_valid: 1'b0, tx_byte: 8'h00,
                                dtr_level: 1'b0, rts_level: 1'b0, break_level: 1'b0,
                                txrdy_level: 1'b1, rxrdy_level: 1'b0, txe_level: 1'b1,
                                syndet_level: 1'b0};
  localparam usrm_pkg::res_t RES_CMD  = '{read_data: 8'h00, tx_valid: 1'b0, tx_byte: 8'h00,
                                dtr_level: 1'b1, rts_level: 1'b1, break_level: 1'b0,
                                txrdy_level: 1'b1, rxrdy_level: 1'b0, txe_level: 1'b1,
                                syndet_level: 1'b0};
  localparam usrm_pkg::res_t NO_RES = '0;

  typedef struct packed {
    logic [2:0]     op;
    logic           addr;
    logic [7:0]     val;
    logic           typed;
    usrm_pkg::res_t res;
  } stim_row_t;

  // Directed rows: idle reads, the sync-mode sequence, a full transmit queue,
  // received bytes and breaks, DSR, flush with an idle expiry, internal reset.
  localparam int DIRECTED_ROWS = 27;
  localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
    '{usrm_pkg::OP_READ,    1'b1, 8'h00, 1'b1, RES_IDLE},
    '{usrm_pkg::OP_READ,    1'b0, 8'h00, 1'b1, RES_IDLE},
    '{OP_NONE,              1'b1, 8'hFF, 1'b1, RES_IDLE},
    '{usrm_pkg::OP_WRITE,   1'b1, 8'h00, 1'b0, NO_RES},
    '{usrm_pkg::OP_WRITE,   1'b1, 8'h16, 1'b0, NO_RES},
    '{usrm_pkg::OP_WRITE,   1'b1, 8'h16, 1'b0, NO_RES},
    '{usrm_pkg::OP_WRITE,   1'b1, 8'h37, 1'b1, RES_CMD},
    '{usrm_pkg::OP_READ,    1'b1, 8'h00, 1'b0, NO_RES},
    '{usrm_pkg::OP_WRITE,   1'b0, 8'h00, 1'b0, NO_RES},
    '{usrm_pkg::OP_WRITE,   1'b0, 8'hFF, 1'b0, NO_RES},
    '{usrm_pkg::OP_WRITE,   1'b0, 8'hA5, 1'b0, NO_RES},
    '{usrm_pkg::OP_WRITE,   1'b0, 8'h5A, 1'b0, NO_RES},
    '{usrm_pkg::OP_WRITE,   1'b0, 8'h11, 1'b0, NO_RES},
    '{usrm_pkg::OP_TICK,    1'b0, 8'h00, 1'b0, NO_RES},
    '{usrm_pkg::OP_RXBYTE,  1'b0, 8'hFF, 1'b0, NO_RES},
    '{usrm_pkg::OP_RXBREAK, 1'b0, 8'h01, 1'b0, NO_RES},
    '{usrm_pkg::OP_RXBREAK, 1'b1, 8'h00, 1'b0, NO_RES},
    '{usrm_pkg::OP_DSR,     1'b0, 8'h80, 1'b0, NO_RES},
    '{usrm_pkg::OP_TICK,    1'b1, 8'hFF, 1'b0, NO_RES},
    '{usrm_pkg::OP_TICK,    1'b0, 8'h00, 1'b0, NO_RES},
    '{usrm_pkg::OP_READ,    1'b0, 8'h00, 1'b0, NO_RES},
    '{usrm_pkg::OP_TICK,    1'b0, 8'h00, 1'b0, NO_RES},
    '{usrm_pkg::OP_READ,    1'b1, 8'h00, 1'b0, NO_RES},
    '{usrm_pkg::OP_RXBYTE,  1'b0, 8'h01, 1'b0, NO_RES},
    '{usrm_pkg::OP_FLUSH,   1'b0, 8'h00, 1'b0, NO_RES},
    '{usrm_pkg::OP_TICK,    1'b0, 8'h00, 1'b0, NO_RES},
    '{usrm_pkg::OP_WRITE,   1'b1, 8'h40, 1'b0, NO_RES}
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  operation = '0;
  logic        address_bit = 1'b0;
  logic [7:0]  value = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  read_data;
  logic        tx_valid;
  logic [7:0]  tx_byte;
  logic        dtr_level;
  logic        rts_level;
  logic        break_level;
  logic        txrdy_level;
  logic        rxrdy_level;
  logic        txe_level;
  logic        syndet_level;

  usart_register_model DUT (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .operation(operation), .address_bit(address_bit), .value(value),
    .out_valid(out_valid), .out_stall(out_stall),
    .read_data(read_data), .tx_valid(tx_valid), .tx_byte(tx_byte),
    .dtr_level(dtr_level), .rts_level(rts_level), .break_level(break_level),
    .txrdy_level(txrdy_level), .rxrdy_level(rxrdy_level),
    .txe_level(txe_level), .syndet_level(syndet_level)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Predictor state: settings, sequencer, status, queues and both timers.
  logic [15:0] rx_delay_setting, tx_delay_setting;
  logic        loop_setting;
  logic [2:0]  seq_phase;
  logic [7:0]  status_reg;
  logic [7:0]  rx_data_reg;
  logic        rx_on, tx_on;
  logic [2:0]  pin_reg;  // bit 0 DTR, bit 1 break, bit 2 RTS
  logic [8:0]  rx_fifo [usrm_pkg::RX_DEPTH];
  int          rx_rd, rx_fill;
  logic [7:0]  tx_fifo [usrm_pkg::TX_DEPTH];
  int          tx_rd, tx_fill;
  logic        rx_busy, tx_busy;
  int          rx_ticks, tx_ticks;
  logic        line_valid;
  logic [7:0]  line_byte;

  usrm_pkg::res_t expected_results [$];
  int   mismatch_count = 0;
  int   items_sent = 0;

  function automatic void reset_usart_state();
    rx_delay_setting = usrm_pkg::DELAY_RESET;
    tx_delay_setting = usrm_pkg::DELAY_RESET;
    loop_setting = 1'b0;
    seq_phase = usrm_pkg::PH_CLEAR;
    status_reg = usrm_pkg::STATUS_RESET;
    rx_data_reg = '0;
    rx_on = 1'b0;
    tx_on = 1'b0;
    pin_reg = '0;
    for (int i = 0; i < usrm_pkg::RX_DEPTH; i++) rx_fifo[i] = '0;
    for (int i = 0; i < usrm_pkg::TX_DEPTH; i++) tx_fifo[i] = '0;
    rx_rd = 0;
    rx_fill = 0;
    tx_rd = 0;
    tx_fill = 0;
    rx_busy = 1'b0;
    tx_busy = 1'b0;
    rx_ticks = 0;
    tx_ticks = 0;
  endfunction

  // A zero delay setting counts as one tick.
  function automatic void arm_rx_timer();
    rx_busy = 1'b1;
    rx_ticks = (rx_delay_setting == 0) ? 1 : int'(rx_delay_setting);
  endfunction

  function automatic void arm_tx_timer();
    tx_busy = 1'b1;
    tx_ticks = (tx_delay_setting == 0) ? 1 : int'(tx_delay_setting);
  endfunction

  // A full receive queue drops the entry, but the timer may still be armed.
  function automatic void rx_fifo_push(logic [8:0] entry);
    if (rx_fill < usrm_pkg::RX_DEPTH) begin
      rx_fifo[(rx_rd + rx_fill) % usrm_pkg::RX_DEPTH] = entry;
      rx_fill++;
    end
    if (rx_on && rx_fill != 0 && !rx_busy) arm_rx_timer();
  endfunction

  // Move one entry into the data register, or flag a break, unless RXRDY is still set.
  function automatic void rx_timer_expire();
    logic [8:0] entry;
    if (rx_on && !status_reg[usrm_pkg::ST_RXRDY] && rx_fill != 0) begin
      entry = rx_fifo[rx_rd];
      rx_rd = (rx_rd + 1) % usrm_pkg::RX_DEPTH;
      rx_fill--;
      if (entry[8]) begin
        status_reg[usrm_pkg::ST_SYNDET] = 1'b1;
      end else begin
        rx_data_reg = entry[7:0];
        status_reg[usrm_pkg::ST_RXRDY] = 1'b1;
      end
    end
    if (rx_on && rx_fill != 0) arm_rx_timer();
    else rx_busy = 1'b0;
  endfunction

  // Send one byte to the line, or back into the receive queue in loopback.
  function automatic void tx_timer_expire();
    logic [7:0] b;
    if (tx_on && tx_fill != 0) begin
      b = tx_fifo[tx_rd];
      tx_rd = (tx_rd + 1) % usrm_pkg::TX_DEPTH;
      tx_fill--;
      if (loop_setting) begin
        rx_fifo_push({1'b0, b});
      end else begin
        line_valid = 1'b1;
        line_byte = b;
      end
      status_reg[usrm_pkg::ST_TXRDY] = 1'b1;
      if (tx_fill == 0) status_reg[usrm_pkg::ST_TXE] = 1'b1;
    end
    if (tx_on && tx_fill != 0) arm_tx_timer();
    else tx_busy = 1'b0;
  endfunction

  // Mode byte, then sync bytes as the mode asks, then commands.
  function automatic void control_reg_write(logic [7:0] d);
    case (seq_phase)
      usrm_pkg::PH_CLEAR: begin
        if (d[1:0] != 2'b00) seq_phase = usrm_pkg::PH_ASYNC;
        else if (d[usrm_pkg::MODE_SINGLE_SYNC]) seq_phase = usrm_pkg::PH_SYNC2;
        else seq_phase = usrm_pkg::PH_SYNC1;
      end
      usrm_pkg::PH_SYNC1: seq_phase = usrm_pkg::PH_SYNC2;
      usrm_pkg::PH_SYNC2: seq_phase = usrm_pkg::PH_SYNC;
      default: begin
        if (d[usrm_pkg::CMD_IR]) begin
          seq_phase = usrm_pkg::PH_CLEAR;
        end else begin
          if (d[usrm_pkg::CMD_ER]) begin
            status_reg[usrm_pkg::ST_PE] = 1'b0;
            status_reg[usrm_pkg::ST_OE] = 1'b0;
            status_reg[usrm_pkg::ST_FE] = 1'b0;
          end
          pin_reg = {d[usrm_pkg::CMD_RTS], d[usrm_pkg::CMD_SBRK], d[usrm_pkg::CMD_DTR]};
          rx_on = d[usrm_pkg::CMD_RXEN];
          if (rx_on && rx_fill != 0 && !rx_busy) arm_rx_timer();
          tx_on = d[usrm_pkg::CMD_TXEN];
          if (tx_on && tx_fill != 0 && !tx_busy) arm_tx_timer();
        end
      end
    endcase
  endfunction

  // Data writes are dropped while TXRDY is low or the transmit queue is full.
  function automatic void tx_data_write(logic [7:0] d);
    if (!status_reg[usrm_pkg::ST_TXRDY] || tx_fill >= usrm_pkg::TX_DEPTH) return;
    tx_fifo[(tx_rd + tx_fill) % usrm_pkg::TX_DEPTH] = d;
    tx_fill++;
    if (tx_fill >= usrm_pkg::TX_DEPTH) status_reg[usrm_pkg::ST_TXRDY] = 1'b0;
    status_reg[usrm_pkg::ST_TXE] = 1'b0;
    if (tx_on && !tx_busy) arm_tx_timer();
  endfunction

  // Apply one item to the predicted state and return the result it causes.
  function automatic usrm_pkg::res_t usart_step(logic [2:0] op, logic a, logic [7:0] v);
    usrm_pkg::res_t r;
    logic [7:0] rd;
    rd = '0;
    line_valid = 1'b0;
    line_byte = '0;
    case (op)
      usrm_pkg::OP_WRITE: begin
        if (a) control_reg_write(v);
        else tx_data_write(v);
      end
      usrm_pkg::OP_READ: begin
        if (a) begin
          // TXRDY and TXE read as zero while the transmitter is off.
          rd = status_reg;
          if (!tx_on) begin
            rd[usrm_pkg::ST_TXRDY] = 1'b0;
            rd[usrm_pkg::ST_TXE] = 1'b0;
          end
        end else begin
          status_reg[usrm_pkg::ST_RXRDY] = 1'b0;
          rd = rx_data_reg;
        end
      end
      usrm_pkg::OP_RXBYTE: rx_fifo_push({1'b0, v});
      usrm_pkg::OP_RXBREAK: if (v != 0) rx_fifo_push(usrm_pkg::RX_BREAK_ENTRY);
      usrm_pkg::OP_DSR: status_reg[usrm_pkg::ST_DSR] = (v != 0);
      usrm_pkg::OP_FLUSH: begin
        rx_fill = 0;
        rx_rd = 0;
      end
      usrm_pkg::OP_TICK: begin
        // The receive timer is serviced before the transmit timer.
        if (rx_busy) begin
          if (rx_ticks > 1) rx_ticks--;
          else begin
            rx_ticks = 0;
            rx_timer_expire();
          end
        end
        if (tx_busy) begin
          if (tx_ticks > 1) tx_ticks--;
          else begin
            tx_ticks = 0;
            tx_timer_expire();
          end
        end
      end
      default: ;
    endcase
    r.read_data = rd;
    r.tx_valid = line_valid;
    r.tx_byte = line_byte;
    r.dtr_level = pin_reg[0];
    r.rts_level = pin_reg[2];
    r.break_level = pin_reg[1];
    r.txrdy_level = status_reg[usrm_pkg::ST_TXRDY];
    r.rxrdy_level = status_reg[usrm_pkg::ST_RXRDY];
    r.txe_level = status_reg[usrm_pkg::ST_TXE];
    r.syndet_level = status_reg[usrm_pkg::ST_SYNDET];
    return r;
  endfunction

  // Offer one item, wait for its transfer, then record what it should produce.
  task automatic send_item(input logic [2:0] op, input logic a, input logic [7:0] v,
                           input logic typed, input usrm_pkg::res_t typed_res);
    int gap;
    usrm_pkg::res_t predicted;
    gap = 0;
    if (items_sent < 700 || items_sent > 1000) begin
      while ($urandom_range(99) < 33) gap++;
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    operation <= op;
    address_bit <= a;
    value <= v;
    do @(posedge clk); while (in_stall);
    items_sent++;
    predicted = usart_step(op, a, v);
    expected_results.push_back(typed ? typed_res : predicted);
  endtask

  // Shape a random item: mostly ticks, data traffic and reception.
  task automatic pick_random_item(output logic [2:0] op, output logic a, output logic [7:0] v);
    int r;
    int k;
    r = $urandom_range(99);
    v = 8'($urandom_range(255));
    a = 1'($urandom_range(1));
    if (r < 34) begin
      op = usrm_pkg::OP_TICK;
    end else if (r < 49) begin
      op = usrm_pkg::OP_WRITE;
      a = 1'b0;
    end else if (r < 57) begin
      op = usrm_pkg::OP_WRITE;
      a = 1'b1;
      // Most control bytes enable both directions so traffic keeps flowing.
      k = $urandom_range(9);
      if (k < 6) begin
        v[usrm_pkg::CMD_TXEN] = 1'b1;
        v[usrm_pkg::CMD_RXEN] = 1'b1;
        v[usrm_pkg::CMD_IR] = 1'b0;
      end else if (k == 6) begin
        v[usrm_pkg::CMD_IR] = 1'b1;
      end
    end else if (r < 66) begin
      op = usrm_pkg::OP_READ;
      a = 1'b0;
    end else if (r < 73) begin
      op = usrm_pkg::OP_READ;
      a = 1'b1;
    end else if (r < 86) begin
      op = usrm_pkg::OP_RXBYTE;
    end else if (r < 91) begin
      op = usrm_pkg::OP_RXBREAK;
      if ($urandom_range(2) == 0) v = '0;
    end else if (r < 95) begin
      op = usrm_pkg::OP_DSR;
      if ($urandom_range(1) == 0) v = '0;
    end else if (r < 98) begin
      op = usrm_pkg::OP_FLUSH;
    end else begin
      op = OP_NONE;
    end
  endtask

  // Stop offering items and wait until every expected result has arrived.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // Write all three registers on consecutive cycles while the block is idle.
  task automatic write_settings(input logic [15:0] rx_dly, input logic [15:0] tx_dly,
                                input logic loop);
    cfg_we <= 1'b1;
    cfg_index <= usrm_pkg::CFG_RX_DELAY;
    cfg_data <= rx_dly;
    @(posedge clk);
    cfg_index <= usrm_pkg::CFG_TX_DELAY;
    cfg_data <= tx_dly;
    @(posedge clk);
    cfg_index <= usrm_pkg::CFG_LOOPBACK;
    cfg_data <= {15'd0, loop};
    @(posedge clk);
    cfg_we <= 1'b0;
    rx_delay_setting = rx_dly;
    tx_delay_setting = tx_dly;
    loop_setting = loop;
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
    end
  endtask

  // Receiver side: random stalls, one quiet stretch, and long hold-offs.
  int stall_cycle = 0;
  int hold_left = 0;
  always @(posedge clk) begin
    stall_cycle++;
    if (stall_cycle == 1200 || stall_cycle == 4000) hold_left = 80;
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (stall_cycle >= 2200 && stall_cycle < 3000) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < 33);
    end
  end

  // Compare every transfer on the result channel with the oldest expectation.
  always @(posedge clk) begin
    usrm_pkg::res_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        mismatch_count++;
        $display("%0t: result with no expectation, read_data %0h tx_valid %0b tx_byte %0h",
                 $time, read_data, tx_valid, tx_byte);
      end else begin
        want = expected_results.pop_front();
        check_field("read_data", want.read_data, read_data);
        check_field("tx_valid", 8'(want.tx_valid), 8'(tx_valid));
        check_field("tx_byte", want.tx_byte, tx_byte);
        check_field("dtr_level", 8'(want.dtr_level), 8'(dtr_level));
        check_field("rts_level", 8'(want.rts_level), 8'(rts_level));
        check_field("break_level", 8'(want.break_level), 8'(break_level));
        check_field("txrdy_level", 8'(want.txrdy_level), 8'(txrdy_level));
        check_field("rxrdy_level", 8'(want.rxrdy_level), 8'(rxrdy_level));
        check_field("txe_level", 8'(want.txe_level), 8'(txe_level));
        check_field("syndet_level", 8'(want.syndet_level), 8'(syndet_level));
      end
    end
  end

  // Watchdog on the whole run.
  int cycle_count = 0;
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Main sequence: reset, directed table, then random phases under several settings.
  initial begin
    logic [2:0] op;
    logic       a;
    logic [7:0] v;
    reset_usart_state();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    write_settings(16'd1, 16'd1, 1'b0);
    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      send_item(DIRECTED[i].op, DIRECTED[i].addr, DIRECTED[i].val,
                DIRECTED[i].typed, DIRECTED[i].res);
    end
    for (int p = 0; p < PHASES; p++) begin
      drain_results();
      write_settings(PHASE_RX_DELAY[p], PHASE_TX_DELAY[p], PHASE_LOOP[p]);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        pick_random_item(op, a, v);
        send_item(op, a, v, 1'b0, NO_RES);
      end
    end
    drain_results();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
